// ===== hdl/srgxy_pkg.sv =====
// shared types, constants and helper functions for the scan range gate
// and polar to xy converter; no dependencies
package srgxy_pkg;

    // field and register widths
    localparam int RANGE_W  = 16;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int ANGLE_W  = 17;
    localparam int STEP_W   = 16;
    localparam int COORD_W  = 17;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // scan length limit and index cap
    localparam int MAX_SAMPLES = 4096;
    localparam int INDEX_LIMIT = (1 << INDEX_W) - 1;
    localparam logic [INDEX_W-1:0] INDEX_CAP =
        INDEX_W'((MAX_SAMPLES - 1 < INDEX_LIMIT) ? MAX_SAMPLES - 1 : INDEX_LIMIT);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register reset values
    localparam logic [RANGE_W-1:0] RANGE_LIMIT_RST = 16'd600;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT_RST = 13'd10;
    localparam logic [ANGLE_W-1:0] ANGLE_START_RST = 17'h18000;
    localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 16'd182;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_LIMIT = 2'd0,
        REG_COUNT_LIMIT = 2'd1,
        REG_ANGLE_START = 2'd2,
        REG_ANGLE_STEP  = 2'd3
    } cfg_reg_t;

    // angle arithmetic
    localparam int ANGLE_SUM_W = 30;
    localparam logic signed [ANGLE_SUM_W-1:0] QUARTER_TURN = 30'sd16384;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // polynomial steps: sine uses 0..3, cosine uses 4..8
    localparam logic [3:0] SIN_LAST_STEP = 4'd3;
    localparam logic [3:0] COS_LAST_STEP = 4'd8;

    // reciprocals floor(2^(32+p)/k), each below 2^32
    localparam logic [31:0] RECIP_72 = 32'((64'd1 << 38) / 64'd72);
    localparam logic [31:0] RECIP_42 = 32'((64'd1 << 37) / 64'd42);
    localparam logic [31:0] RECIP_20 = 32'((64'd1 << 36) / 64'd20);
    localparam logic [31:0] RECIP_6  = 32'((64'd1 << 34) / 64'd6);
    localparam logic [31:0] RECIP_90 = 32'((64'd1 << 38) / 64'd90);
    localparam logic [31:0] RECIP_56 = 32'((64'd1 << 37) / 64'd56);
    localparam logic [31:0] RECIP_30 = 32'((64'd1 << 36) / 64'd30);
    localparam logic [31:0] RECIP_12 = 32'((64'd1 << 35) / 64'd12);
    localparam logic [31:0] RECIP_2  = 32'((64'd1 << 32) / 64'd2);

    // trig sequencer states
    typedef enum logic [3:0] {
        C_IDLE,
        C_ANGLE,
        C_GATE,
        C_XR,
        C_XSQ,
        C_X2,
        C_H_XF,
        C_H_REC,
        C_H_BACK,
        C_H_FIX,
        C_SIN,
        C_SINQ,
        C_COSQ,
        C_XMUL,
        C_YMUL,
        C_YFIN
    } core_state_t;

    // one job handed to the trig unit
    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic [INDEX_W-1:0] sample_index;
        logic [RANGE_W-1:0] range_limit;
        logic [ANGLE_W-1:0] angle_start;
        logic [STEP_W-1:0]  angle_step;
    } job_t;

    // result of the trig unit
    typedef struct packed {
        logic               point_valid;
        logic [COORD_W-1:0] x_mm;
        logic [COORD_W-1:0] y_mm;
    } point_t;

    // trig unit status
    typedef struct packed {
        logic idle;
        logic done;
    } core_status_t;

    // divisor per polynomial step
    function automatic logic [6:0] divisor_of(input logic [3:0] step);
        logic [6:0] k;
        unique case (step)
            4'd0:    k = 7'd72;
            4'd1:    k = 7'd42;
            4'd2:    k = 7'd20;
            4'd3:    k = 7'd6;
            4'd4:    k = 7'd90;
            4'd5:    k = 7'd56;
            4'd6:    k = 7'd30;
            4'd7:    k = 7'd12;
            4'd8:    k = 7'd2;
            default: k = 7'd2;
        endcase
        return k;
    endfunction

    // reciprocal per polynomial step
    function automatic logic [31:0] recip_of(input logic [3:0] step);
        logic [31:0] m;
        unique case (step)
            4'd0:    m = RECIP_72;
            4'd1:    m = RECIP_42;
            4'd2:    m = RECIP_20;
            4'd3:    m = RECIP_6;
            4'd4:    m = RECIP_90;
            4'd5:    m = RECIP_56;
            4'd6:    m = RECIP_30;
            4'd7:    m = RECIP_12;
            4'd8:    m = RECIP_2;
            default: m = RECIP_2;
        endcase
        return m;
    endfunction

    // extra right shift beyond 32 per polynomial step
    function automatic logic [2:0] shift_of(input logic [3:0] step);
        logic [2:0] p;
        unique case (step)
            4'd0:    p = 3'd6;
            4'd1:    p = 3'd5;
            4'd2:    p = 3'd4;
            4'd3:    p = 3'd2;
            4'd4:    p = 3'd6;
            4'd5:    p = 3'd5;
            4'd6:    p = 3'd4;
            4'd7:    p = 3'd3;
            4'd8:    p = 3'd0;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

    // q30 to q0.15 with round to nearest and saturation
    function automatic logic [14:0] q30_to_q15(input logic [31:0] v);
        logic [32:0] r;
        r = {1'b0, v} + 33'd16384;
        if (r[32:15] > 18'd32767)
            return 15'h7fff;
        return r[29:15];
    endfunction

endpackage

// ===== hdl/scan_range_gate_polar_to_xy_core.sv =====
// Lidar scan range gate with polar to xy conversion, top level. One range sample
// enters per beat; its angle is angle_start + angle_step * index (65536 units per
// turn). A sample below the range limit and strictly inside a quarter turn either
// side becomes a point with x, y in mm from q0.15 polynomial sine and cosine. Every
// sample yields one result beat; the beat with tlast reports stop when the scan's
// accepted count exceeds the count limit, and clears index and count. One shared
// 32x32 multiplier is stepped by the sequencer through angle, radians, square, nine
// polynomial divide steps (product, reciprocal estimate, back-multiply, correction),
// the sine product and the two coordinate products; a rejected sample goes from the
// gate straight to the result state.
// The input is ready only while the sequencer is idle; a result register lets the
// next sample start while a result waits, and while that register is still full
// the sequencer holds its finished sample and the input stays not ready.
// depends on srgxy_pkg, srgxy_trig and srgxy_mul
module scan_range_gate_polar_to_xy_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // input samples
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [srgxy_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] range_mm
    input  logic                              s_tlast,   // last_sample
    // output points
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [srgxy_pkg::OUT_DATA_W-1:0]  m_tdata,   // [0] point_valid, [17:1] x_mm,
                                                         // [34:18] y_mm, [35] stop, rest 0
    output logic                              m_tlast,   // scan_done
    // configuration writes
    input  logic                              cfg_we,
    input  logic [srgxy_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srgxy_pkg::CFG_W-1:0]       cfg_data
);
    import srgxy_pkg::*;

    logic [RANGE_W-1:0] range_limit_reg;
    logic [COUNT_W-1:0] count_limit_reg;
    logic [ANGLE_W-1:0] angle_start_reg;
    logic [STEP_W-1:0]  angle_step_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               last_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic               out_last_reg;

    job_t         job;
    point_t       point;
    core_status_t status;
    logic         accept;
    logic         take;
    logic [COUNT_W-1:0] count_inc;
    logic         stop;

    // handshake
    assign s_tready = status.idle;
    assign accept   = s_tvalid && s_tready;
    assign take     = status.done && (!out_valid_reg || m_tready);

    assign job.range_mm     = s_tdata[RANGE_W-1:0];
    assign job.sample_index = index_reg;
    assign job.range_limit  = range_limit_reg;
    assign job.angle_start  = angle_start_reg;
    assign job.angle_step   = angle_step_reg;

    srgxy_trig u_trig (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .job    (job),
        .take   (take),
        .status (status),
        .point  (point)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_limit_reg <= RANGE_LIMIT_RST;
            count_limit_reg <= COUNT_LIMIT_RST;
            angle_start_reg <= ANGLE_START_RST;
            angle_step_reg  <= ANGLE_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RANGE_LIMIT: range_limit_reg <= cfg_data[RANGE_W-1:0];
                REG_COUNT_LIMIT: count_limit_reg <= cfg_data[COUNT_W-1:0];
                REG_ANGLE_START: angle_start_reg <= cfg_data[ANGLE_W-1:0];
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_data[STEP_W-1:0];
                default:         range_limit_reg <= range_limit_reg;
            endcase
        end
    end

    // scan index, accepted count and stop decision
    always_comb
    begin
        count_inc = (point.point_valid && count_reg != COUNT_MAX) ? count_reg + 13'd1
                                                                   : count_reg;
        stop = last_reg && (count_inc > count_limit_reg);
        if (last_reg)
        begin
            index_next = '0;
            count_next = '0;
        end
        else
        begin
            index_next = (index_reg < INDEX_CAP) ? index_reg + 12'd1 : index_reg;
            count_next = count_inc;
        end
        out_data_next = {{(OUT_DATA_W - 2 - 2*COORD_W){1'b0}}, stop,
                         point.y_mm, point.x_mm, point.point_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                index_reg     <= index_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sample flag and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            last_reg <= s_tlast;
        if (take)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // index never passes its cap
    assert property (@(posedge clk) disable iff (!rst_n) index_reg <= INDEX_CAP)
        else $error("sample index beyond cap");

    // accepting a sample makes the sequencer busy
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !s_tready)
        else $error("input ready right after accept");

    // a rejected sample carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !point.point_valid) |-> (point.x_mm == '0 && point.y_mm == '0))
        else $error("rejected sample with nonzero coordinates");

    // end of scan clears index and count
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_reg) |=> (index_reg == '0 && count_reg == '0))
        else $error("scan end did not clear state");

    // a finished result and an idle sequencer exclude each other
    assert property (@(posedge clk) disable iff (!rst_n) !(status.idle && status.done))
        else $error("sequencer idle and done at once");

endmodule

// ===== hdl/srgxy_mul.sv =====
// shared 32 by 32 unsigned multiplier with registered product
// depends on nothing but the clock
module srgxy_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    // one product per cycle
    assign prod_next = {32'd0, a} * {32'd0, b};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/srgxy_trig.sv =====
// range and angle gate plus sine and cosine polynomial sequencer
// depends on srgxy_pkg and the shared multiplier srgxy_mul
module srgxy_trig (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  srgxy_pkg::job_t        job,
    input  logic                   take,
    output srgxy_pkg::core_status_t status,
    output srgxy_pkg::point_t      point
);
    import srgxy_pkg::*;

    core_state_t state_reg;
    core_state_t state_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    job_t          job_reg;
    logic          valid_reg;
    logic          neg_reg;
    logic [13:0]   u_reg;
    logic [30:0]   xr_reg;
    logic [31:0]   x2_reg;
    logic [30:0]   f_reg;
    logic [3:0]    step_reg;
    logic [31:0]   t_reg;
    logic [31:0]   q0_reg;
    logic [14:0]   s_reg;
    logic [14:0]   c_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic          done_seen_reg;

    logic signed [ANGLE_SUM_W-1:0] angle;
    logic [ANGLE_SUM_W-1:0]        angle_mag;
    logic                          gate_pass;
    logic [31:0]                   q0;
    logic [31:0]                   rem;
    logic [31:0]                   q_fix;
    logic [30:0]                   f_fix;
    logic [31:0]                   rnd;
    logic                          done;

    srgxy_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // angle of the sample and the gate
    always_comb
    begin
        angle = {{(ANGLE_SUM_W-ANGLE_W){job_reg.angle_start[ANGLE_W-1]}}, job_reg.angle_start}
              + {2'b00, prod[27:0]};
        angle_mag = angle[ANGLE_SUM_W-1] ? (ANGLE_SUM_W'(0) - angle) : angle;
        gate_pass = (job_reg.range_mm < job_reg.range_limit)
                 && (angle > -QUARTER_TURN) && (angle < QUARTER_TURN);
    end

    // divide by step constant: reciprocal estimate, then one correction
    always_comb
    begin
        q0    = prod[63:32] >> shift_of(step_reg);
        rem   = t_reg - prod[31:0];
        q_fix = q0_reg + {31'd0, (rem >= {25'd0, divisor_of(step_reg)})};
        f_fix = (q_fix >= {1'b0, ONE_Q30}) ? 31'd0 : 31'({1'b0, ONE_Q30} - q_fix);
        rnd   = prod[31:0] + 32'd16384;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and multiplier operands
    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        done       = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                    state_next = C_ANGLE;
            end
            C_ANGLE:
            begin
                mul_a      = 32'(job_reg.angle_step);
                mul_b      = 32'(job_reg.sample_index);
                state_next = C_GATE;
            end
            C_GATE:
            begin
                state_next = gate_pass ? C_XR : C_YFIN;
            end
            C_XR:
            begin
                mul_a      = 32'(u_reg);
                mul_b      = PI_Q30;
                state_next = C_XSQ;
            end
            C_XSQ:
            begin
                mul_a      = {1'b0, prod[45:15]};
                mul_b      = {1'b0, prod[45:15]};
                state_next = C_X2;
            end
            C_X2:
            begin
                state_next = C_H_XF;
            end
            C_H_XF:
            begin
                mul_a      = x2_reg;
                mul_b      = {1'b0, f_reg};
                state_next = C_H_REC;
            end
            C_H_REC:
            begin
                mul_a      = prod[61:30];
                mul_b      = recip_of(step_reg);
                state_next = C_H_BACK;
            end
            C_H_BACK:
            begin
                mul_a      = q0;
                mul_b      = 32'(divisor_of(step_reg));
                state_next = C_H_FIX;
            end
            C_H_FIX:
            begin
                if (step_reg == SIN_LAST_STEP)
                    state_next = C_SIN;
                else if (step_reg == COS_LAST_STEP)
                    state_next = C_COSQ;
                else
                    state_next = C_H_XF;
            end
            C_SIN:
            begin
                mul_a      = {1'b0, xr_reg};
                mul_b      = {1'b0, f_reg};
                state_next = C_SINQ;
            end
            C_SINQ:
            begin
                state_next = C_H_XF;
            end
            C_COSQ:
            begin
                state_next = C_XMUL;
            end
            C_XMUL:
            begin
                mul_a      = 32'(job_reg.range_mm);
                mul_b      = 32'(c_reg);
                state_next = C_YMUL;
            end
            C_YMUL:
            begin
                mul_a      = 32'(job_reg.range_mm);
                mul_b      = 32'(s_reg);
                state_next = C_YFIN;
            end
            C_YFIN:
            begin
                // rejected samples wait here too, x and y already zero
                done = !valid_reg || done_seen_reg;
                if (done && take)
                    state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // marks that the y result has been written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_seen_reg <= 1'b0;
        else if (state_reg == C_YFIN)
            done_seen_reg <= 1'b1;
        else
            done_seen_reg <= 1'b0;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                    job_reg <= job;
            end
            C_GATE:
            begin
                valid_reg <= gate_pass;
                neg_reg   <= angle[ANGLE_SUM_W-1];
                u_reg     <= angle_mag[13:0];
                x_reg     <= '0;
                y_reg     <= '0;
            end
            C_XSQ:
            begin
                xr_reg <= prod[45:15];
            end
            C_X2:
            begin
                x2_reg   <= prod[61:30];
                f_reg    <= ONE_Q30;
                step_reg <= 4'd0;
            end
            C_H_REC:
            begin
                t_reg <= prod[61:30];
            end
            C_H_BACK:
            begin
                q0_reg <= q0;
            end
            C_H_FIX:
            begin
                f_reg    <= f_fix;
                step_reg <= step_reg + 4'd1;
            end
            C_SINQ:
            begin
                s_reg <= q30_to_q15(prod[61:30]);
                f_reg <= ONE_Q30;
            end
            C_COSQ:
            begin
                c_reg <= q30_to_q15({1'b0, f_reg});
            end
            C_YMUL:
            begin
                x_reg <= rnd[31:15];
            end
            C_YFIN:
            begin
                if (valid_reg && !done_seen_reg)
                    y_reg <= neg_reg ? (COORD_W'(0) - rnd[31:15]) : rnd[31:15];
            end
            default:
            begin
            end
        endcase
    end

    assign status.idle      = (state_reg == C_IDLE);
    assign status.done      = done;
    assign point.point_valid = valid_reg;
    assign point.x_mm        = x_reg;
    assign point.y_mm        = y_reg;

endmodule

// ===== sim/srgxy_point_checker.sv =====
// checker for the scan range gate core: predicts each result beat from the input
// beats and register writes, and compares it with what the core puts out
// depends on srgxy_pkg
`timescale 1ns / 100ps

module srgxy_point_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [srgxy_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] range_mm
    input  logic                              s_tlast,   // last_sample
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [srgxy_pkg::OUT_DATA_W-1:0]  m_tdata,   // [0] point_valid, [17:1] x_mm,
                                                         // [34:18] y_mm, [35] stop, rest 0
    input  logic                              m_tlast,   // scan_done
    input  logic                              cfg_we,
    input  logic [srgxy_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srgxy_pkg::CFG_W-1:0]       cfg_data,
    output int                                mismatches,
    output int                                outstanding
);
    import srgxy_pkg::*;

    // fixed-point constants of the polynomial sine and cosine
    localparam logic [63:0] TRIG_PI_Q30 = 64'd3373259426;
    localparam logic [63:0] UNIT_Q30    = 64'd1 << 30;
    localparam logic [63:0] HALF_LSB    = 64'd16384;
    localparam logic [63:0] Q15_MAX     = 64'd32767;
    localparam longint      GATE_LIMIT  = 16384;
    localparam int          COUNT_SAT   = 8191;
    localparam int          INDEX_TOP   = (MAX_SAMPLES - 1 < 4095) ? MAX_SAMPLES - 1 : 4095;

    typedef struct packed {
        logic               point_valid;
        logic [COORD_W-1:0] x_mm;
        logic [COORD_W-1:0] y_mm;
        logic               scan_done;
        logic               stop;
    } scan_point_t;

    // register copies and scan state
    logic [15:0]        dist_lim;
    logic [12:0]        size_lim;
    logic signed [16:0] start_ang;
    logic [15:0]        step_ang;
    int                 scan_idx;
    int                 scan_count;

    scan_point_t        pending_points[$];

    // one horner step: one minus the scaled product, floored at zero
    function automatic logic [63:0] poly_step(input logic [63:0] x2, input logic [63:0] f,
                                              input logic [63:0] k);
        logic [63:0] t;
        t = ((x2 * f) >> 30) / k;
        return (t >= UNIT_Q30) ? 64'd0 : UNIT_Q30 - t;
    endfunction

    // q30 down to q0.15, rounded and saturated
    function automatic logic [14:0] to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + HALF_LSB) >> 15;
        return (r > Q15_MAX) ? 15'h7fff : r[14:0];
    endfunction

    // gate one sample, convert it and advance the scan state
    function automatic scan_point_t predict_point(input logic [15:0] rng, input logic last);
        scan_point_t p;
        longint      ang;
        logic [63:0] u;
        logic [63:0] xr;
        logic [63:0] x2;
        logic [63:0] f;
        logic [14:0] sn;
        logic [14:0] cs;
        logic [63:0] mag;
        p = '0;
        ang = longint'(start_ang) + longint'(step_ang) * longint'(scan_idx);
        if (rng < dist_lim && ang > -GATE_LIMIT && ang < GATE_LIMIT)
        begin
            u  = (ang < 0) ? 64'(-ang) : 64'(ang);
            xr = (u * TRIG_PI_Q30) >> 15;
            x2 = (xr * xr) >> 30;
            // sine series
            f  = UNIT_Q30;
            f  = poly_step(x2, f, 64'd72);
            f  = poly_step(x2, f, 64'd42);
            f  = poly_step(x2, f, 64'd20);
            f  = poly_step(x2, f, 64'd6);
            sn = to_q15((xr * f) >> 30);
            // cosine series
            f  = UNIT_Q30;
            f  = poly_step(x2, f, 64'd90);
            f  = poly_step(x2, f, 64'd56);
            f  = poly_step(x2, f, 64'd30);
            f  = poly_step(x2, f, 64'd12);
            f  = poly_step(x2, f, 64'd2);
            cs = to_q15(f);
            p.point_valid = 1'b1;
            p.x_mm = COORD_W'((64'(rng) * 64'(cs) + HALF_LSB) >> 15);
            mag    = (64'(rng) * 64'(sn) + HALF_LSB) >> 15;
            p.y_mm = (ang < 0) ? COORD_W'(64'd0 - mag) : COORD_W'(mag);
            if (scan_count < COUNT_SAT)
                scan_count++;
        end
        p.scan_done = last;
        if (last)
        begin
            p.stop = (scan_count > int'(size_lim));
            scan_idx = 0;
            scan_count = 0;
        end
        else if (scan_idx < INDEX_TOP)
        begin
            scan_idx++;
        end
        return p;
    endfunction

    task automatic flag_field(input string field, input longint want_v, input longint got_v);
        mismatches++;
        $error("%s: expected %0d, actual %0d", field, want_v, got_v);
    endtask

    // watch register writes, input beats and result beats
    always @(posedge clk or negedge rst_n)
    begin
        scan_point_t want;
        scan_point_t got;
        if (!rst_n)
        begin
            dist_lim    = RANGE_LIMIT_RST;
            size_lim    = COUNT_LIMIT_RST;
            start_ang   = ANGLE_START_RST;
            step_ang    = ANGLE_STEP_RST;
            scan_idx    = 0;
            scan_count  = 0;
            mismatches  = 0;
            outstanding = 0;
            pending_points.delete();
        end
        else
        begin
            // result beat against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                got.point_valid = m_tdata[0];
                got.x_mm        = m_tdata[17:1];
                got.y_mm        = m_tdata[34:18];
                got.stop        = m_tdata[35];
                got.scan_done   = m_tlast;
                if (pending_points.size() == 0)
                    flag_field("unexpected result beat", 0, 1);
                else
                begin
                    want = pending_points.pop_front();
                    if (got.point_valid != want.point_valid)
                        flag_field("point_valid", want.point_valid, got.point_valid);
                    if (got.x_mm != want.x_mm)
                        flag_field("x_mm", longint'($signed(want.x_mm)),
                                   longint'($signed(got.x_mm)));
                    if (got.y_mm != want.y_mm)
                        flag_field("y_mm", longint'($signed(want.y_mm)),
                                   longint'($signed(got.y_mm)));
                    if (got.scan_done != want.scan_done)
                        flag_field("scan_done", want.scan_done, got.scan_done);
                    if (got.stop != want.stop)
                        flag_field("stop", want.stop, got.stop);
                    if (m_tdata[OUT_DATA_W-1:36] != '0)
                        flag_field("tdata padding", 0, m_tdata[OUT_DATA_W-1:36]);
                end
            end

            // input beat: predict its result and queue it at the tail
            if (s_tvalid && s_tready)
                pending_points.insert(pending_points.size(),
                                      predict_point(s_tdata[15:0], s_tlast));

            // register write, masked to register width
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RANGE_LIMIT: dist_lim  = cfg_data[15:0];
                    REG_COUNT_LIMIT: size_lim  = cfg_data[12:0];
                    REG_ANGLE_START: start_ang = cfg_data[16:0];
                    REG_ANGLE_STEP:  step_ang  = cfg_data[15:0];
                    default:         ;
                endcase
            end

            outstanding = pending_points.size();
        end
    end

endmodule

// ===== sim/tb_scan_range_gate_polar_to_xy_core.sv =====
// testbench top for the scan range gate core: clock, reset, register writes,
// sample beats and result back-pressure; verdict from srgxy_point_checker
// depends on srgxy_pkg, scan_range_gate_polar_to_xy_core and srgxy_point_checker
`timescale 1ns / 100ps

module tb_scan_range_gate_polar_to_xy_core;
    import srgxy_pkg::*;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 100;
    localparam int LONG_SCAN     = 150;
    localparam int HOLD_CYCLES   = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;      // [15:0] range_mm
    logic                  s_tlast = 1'b0;    // last_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;           // [0] point_valid, [17:1] x_mm,
                                              // [34:18] y_mm, [35] stop, rest 0
    logic                  m_tlast;           // scan_done
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    int mismatches;
    int outstanding;

    // idling controls shared by sender and receiver
    int gap_pct   = 0;
    int stall_pct = 0;
    bit quiet     = 1'b0;
    bit hold_req  = 1'b0;

    always #6 clk = ~clk;

    scan_range_gate_polar_to_xy_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srgxy_point_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // offer one sample beat, wait for its acceptance, then maybe idle a little
    task automatic send_sample(input logic [15:0] rng, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= rng;
        s_tlast  <= last;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        if (!quiet && gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // stop offering and wait until every result beat has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // write all four registers with raw values, one per cycle
    task automatic write_regs(input logic [CFG_W-1:0] dist_v, input logic [CFG_W-1:0] size_v,
                              input logic [CFG_W-1:0] start_v, input logic [CFG_W-1:0] step_v);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RANGE_LIMIT;
        cfg_data  <= dist_v;
        @(posedge clk);
        cfg_index <= REG_COUNT_LIMIT;
        cfg_data  <= size_v;
        @(posedge clk);
        cfg_index <= REG_ANGLE_START;
        cfg_data  <= start_v;
        @(posedge clk);
        cfg_index <= REG_ANGLE_STEP;
        cfg_data  <= step_v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // receiver: random stall bursts and one long hold-off on request
    initial
    begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int          ph;
        int          n;
        int          k;
        int          scan_left;
        logic [15:0] rng;
        logic [CFG_W-1:0] dist_v;
        logic [CFG_W-1:0] size_v;
        logic [CFG_W-1:0] start_v;
        logic [CFG_W-1:0] step_v;

        scan_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: sample 0 sits half a turn back and is rejected
        send_sample(16'd100, 1'b1);
        drain();

        // angles just inside both quarter-turn edges, zero and widest ranges
        write_regs(17'd65535, 17'd0, 17'h1C001, 17'd16383);
        send_sample(16'd0, 1'b0);
        send_sample(16'd65534, 1'b0);
        send_sample(16'd30000, 1'b0);
        send_sample(16'd500, 1'b1);
        drain();

        // exact quarter-turn edges, range equal to the limit, no return,
        // and register bits above each width that must be dropped
        write_regs(17'h10258, 17'h1E001, 17'h1C000, 17'h14000);
        send_sample(16'd10, 1'b0);
        send_sample(16'd599, 1'b0);
        send_sample(16'd10, 1'b0);
        send_sample(16'd65535, 1'b1);
        send_sample(16'd10, 1'b0);
        send_sample(16'd600, 1'b1);
        drain();

        // zero distance limit accepts nothing
        write_regs(17'd0, 17'd8191, 17'd0, 17'd0);
        send_sample(16'd0, 1'b1);
        drain();

        // negative angle, single-sample scans, no return with the widest limit
        write_regs(17'd65535, 17'd0, 17'h1E000, 17'd0);
        send_sample(16'd65535, 1'b1);
        send_sample(16'd40000, 1'b1);
        drain();

        // one longer scan that walks out past the upper quarter-turn edge
        gap_pct   = 10;
        stall_pct = 10;
        write_regs(17'd65535, 17'd40, 17'h1F001, 17'd200);
        for (n = 0; n < LONG_SCAN; n++)
            send_sample(16'($urandom_range(0, 65534)), n == LONG_SCAN - 1);
        drain();

        // random phases, each with its own register setting
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    dist_v  = 17'd65535;
                    size_v  = 17'd0;
                    start_v = 17'h10000;
                    step_v  = 17'd65535;
                end
                1:
                begin
                    dist_v  = 17'd0;
                    size_v  = 17'd8191;
                    start_v = 17'h0FFFF;
                    step_v  = 17'd0;
                end
                default:
                begin
                    dist_v  = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(0, 65535))
                                                       : CFG_W'($urandom_range(200, 65535));
                    size_v  = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(0, 8191))
                                                       : CFG_W'($urandom_range(0, 30));
                    start_v = CFG_W'(int'($urandom_range(0, 24000)) - 20000);
                    step_v  = ($urandom_range(5) == 0) ? CFG_W'($urandom_range(0, 65535))
                                                       : CFG_W'($urandom_range(0, 1500));
                end
            endcase
            write_regs(dist_v, size_v, start_v, step_v);
            gap_pct   = $urandom_range(0, 2) * 20;
            stall_pct = $urandom_range(0, 2) * 20;
            quiet     = (ph == RANDOM_PHASES - 1);
            if (ph == 2)
                hold_req = 1'b1;

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (scan_left == 0)
                    scan_left = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 40);
                // mostly ranges under the limit, some no-return and full-scale noise
                k = $urandom_range(9);
                if (k == 0)
                    rng = 16'hFFFF;
                else if (k == 1 || dist_v[15:0] == 16'd0)
                    rng = 16'($urandom);
                else
                    rng = 16'($urandom_range(0, dist_v[15:0] - 16'd1));
                send_sample(rng, scan_left == 1);
                scan_left--;
            end
            drain();
        end

        // let any stray beat show up before the verdict
        repeat (60) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_scan_range_gate_polar_to_xy_core: clean");
        else
            $display("tb_scan_range_gate_polar_to_xy_core: errors");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("tb_scan_range_gate_polar_to_xy_core: errors");
        $finish;
    end

endmodule
